// ===== src/stpcal_pkg.sv =====
package stpcal_pkg;

   // default width of the step counters
   localparam int CountWidth = 16;

   // operation codes of a request
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_CAL   = 2'd1,
      OP_RUN   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   // status codes of a response
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOCAL   = 2'd1,
      STATUS_BADLEN  = 2'd2,
      STATUS_BUSY    = 2'd3
   } status_type;

   // motion modes
   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_SEEK = 3'd1,
      MODE_LOW  = 3'd2,
      MODE_HIGH = 3'd3,
      MODE_RUN  = 3'd4
   } mode_type;

   // one response transaction
   typedef struct packed {
      logic [3:0]  coil_pattern;
      logic        moving;
      logic        is_calibrated;
      logic [15:0] revolution_steps;
      status_type  status_code;
   } result_type;

   // half-step coil table, bit3 is coil one
   function automatic logic [3:0] half_step(input logic [2:0] phase);
      logic [3:0] pattern;
      case (phase)
         3'd0: pattern = 4'b1000;
         3'd1: pattern = 4'b1100;
         3'd2: pattern = 4'b0100;
         3'd3: pattern = 4'b0110;
         3'd4: pattern = 4'b0010;
         3'd5: pattern = 4'b0011;
         3'd6: pattern = 4'b0001;
         3'd7: pattern = 4'b1001;
         default: pattern = 4'b0000;
      endcase
      return pattern;
   endfunction

endpackage

// ===== src/stpcal_ifs.sv =====
interface stpcal_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic       sensor_level;
   logic [3:0] run_eighths;

   modport source (output valid, output operation, output sensor_level,
                   output run_eighths, input ready);
   modport sink (input valid, input operation, input sensor_level,
                 input run_eighths, output ready);
endinterface

interface stpcal_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  coil_pattern;
   logic        moving;
   logic        is_calibrated;
   logic [15:0] revolution_steps;
   logic [1:0]  status_code;

   modport source (output valid, output coil_pattern, output moving,
                   output is_calibrated, output revolution_steps,
                   output status_code, input ready);
   modport sink (input valid, input coil_pattern, input moving,
                 input is_calibrated, input revolution_steps,
                 input status_code, output ready);
endinterface

// ===== src/stpcal_core.sv =====
module stpcal_core #(
   parameter int COUNT_WIDTH = stpcal_pkg::CountWidth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             operation,
   input  logic                   sensor_level,
   input  logic [3:0]             run_eighths,
   output stpcal_pkg::result_type result
);

   localparam int ProdWidth = COUNT_WIDTH + 4;

   stpcal_pkg::mode_type   mode_ff, mode_in;
   logic [2:0]             phase_ff, phase_in;
   logic [1:0]             cycle_ff, cycle_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   // count divided by three, kept alongside the counter
   logic [COUNT_WIDTH-1:0] third_ff, third_in;
   logic [1:0]             rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] target_ff, target_in;
   logic [COUNT_WIDTH-1:0] spr_ff, spr_in;
   logic                   cal_ff, cal_in;
   logic [3:0]             coil_ff, coil_in;

   logic [COUNT_WIDTH-1:0] count_step;
   logic [COUNT_WIDTH-1:0] third_step;
   logic [1:0]             rem_step;
   logic [COUNT_WIDTH-1:0] eighth;
   logic [3:0]             mult;
   logic [ProdWidth-1:0]   prod;
   logic [31:0]            spr_wide;
   stpcal_pkg::status_type status;

   // saturating step count with running quotient by three
   always_comb begin
      count_step = count_ff;
      third_step = third_ff;
      rem_step   = rem_ff;
      if (count_ff != {COUNT_WIDTH{1'b1}}) begin
         count_step = count_ff + COUNT_WIDTH'(1);
         if (rem_ff == 2'd2) begin
            rem_step   = 2'd0;
            third_step = third_ff + COUNT_WIDTH'(1);
         end else begin
            rem_step = rem_ff + 2'd1;
         end
      end
   end

   // run length in steps
   assign eighth = spr_ff >> 3;
   assign mult   = (run_eighths == 4'd0) ? 4'd8 : run_eighths;
   assign prod   = ProdWidth'(eighth) * ProdWidth'(mult);

   // next state and status
   always_comb begin
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      cycle_in  = cycle_ff;
      count_in  = count_ff;
      third_in  = third_ff;
      rem_in    = rem_ff;
      target_in = target_ff;
      spr_in    = spr_ff;
      cal_in    = cal_ff;
      coil_in   = coil_ff;
      status    = stpcal_pkg::STATUS_OK;
      case (stpcal_pkg::op_type'(operation))
         stpcal_pkg::OP_TICK: begin
            if (mode_ff != stpcal_pkg::MODE_IDLE) begin
               coil_in  = stpcal_pkg::half_step(phase_ff);
               phase_in = phase_ff + 3'd1;
            end
            case (mode_ff)
               stpcal_pkg::MODE_SEEK: begin
                  if (!sensor_level) begin
                     mode_in = stpcal_pkg::MODE_LOW;
                  end
               end
               stpcal_pkg::MODE_LOW: begin
                  count_in = count_step;
                  third_in = third_step;
                  rem_in   = rem_step;
                  if (sensor_level) begin
                     mode_in = stpcal_pkg::MODE_HIGH;
                  end
               end
               stpcal_pkg::MODE_HIGH: begin
                  count_in = count_step;
                  third_in = third_step;
                  rem_in   = rem_step;
                  if (!sensor_level) begin
                     if (cycle_ff == 2'd2) begin
                        spr_in    = third_step;
                        cal_in    = 1'b1;
                        target_in = '0;
                        cycle_in  = 2'd0;
                        mode_in   = stpcal_pkg::MODE_IDLE;
                     end else begin
                        cycle_in = cycle_ff + 2'd1;
                        mode_in  = stpcal_pkg::MODE_LOW;
                     end
                  end
               end
               stpcal_pkg::MODE_RUN: begin
                  count_in = count_step;
                  third_in = third_step;
                  rem_in   = rem_step;
                  if (count_step >= target_ff) begin
                     mode_in = stpcal_pkg::MODE_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         stpcal_pkg::OP_CAL: begin
            if (mode_ff != stpcal_pkg::MODE_IDLE) begin
               status = stpcal_pkg::STATUS_BUSY;
            end else begin
               count_in = '0;
               third_in = '0;
               rem_in   = 2'd0;
               cycle_in = 2'd0;
               mode_in  = sensor_level ? stpcal_pkg::MODE_SEEK : stpcal_pkg::MODE_LOW;
            end
         end
         stpcal_pkg::OP_RUN: begin
            if (mode_ff != stpcal_pkg::MODE_IDLE) begin
               status = stpcal_pkg::STATUS_BUSY;
            end else if (!cal_ff) begin
               status = stpcal_pkg::STATUS_NOCAL;
            end else if (run_eighths > 4'd8) begin
               status = stpcal_pkg::STATUS_BADLEN;
            end else begin
               // clamp to one revolution
               if (prod > ProdWidth'(spr_ff)) begin
                  target_in = spr_ff;
               end else begin
                  target_in = prod[COUNT_WIDTH-1:0];
               end
               count_in = '0;
               third_in = '0;
               rem_in   = 2'd0;
               if (target_in != '0) begin
                  mode_in = stpcal_pkg::MODE_RUN;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // state registers, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stpcal_pkg::MODE_IDLE;
         phase_ff  <= 3'd0;
         cycle_ff  <= 2'd0;
         count_ff  <= '0;
         third_ff  <= '0;
         rem_ff    <= 2'd0;
         target_ff <= '0;
         spr_ff    <= '0;
         cal_ff    <= 1'b0;
         coil_ff   <= 4'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         cycle_ff  <= cycle_in;
         count_ff  <= count_in;
         third_ff  <= third_in;
         rem_ff    <= rem_in;
         target_ff <= target_in;
         spr_ff    <= spr_in;
         cal_ff    <= cal_in;
         coil_ff   <= coil_in;
      end
   end

   // response fields from the updated state
   assign spr_wide = 32'(spr_in);

   always_comb begin
      result.coil_pattern  = coil_in;
      result.moving        = (mode_in != stpcal_pkg::MODE_IDLE);
      result.is_calibrated = cal_in;
      if (spr_wide > 32'd65535) begin
         result.revolution_steps = 16'hFFFF;
      end else begin
         result.revolution_steps = spr_wide[15:0];
      end
      result.status_code = status;
   end

endmodule

// ===== src/stpcal_skid.sv =====
module stpcal_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  stpcal_pkg::result_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output stpcal_pkg::result_type out_data
);

   logic                   out_valid_ff;
   stpcal_pkg::result_type out_data_ff;
   logic                   skid_valid_ff;
   stpcal_pkg::result_type skid_data_ff;
   logic                   in_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_fire;
         end
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

// ===== src/stepper_half_step_calibrating_driver_unit.sv =====
// half-step stepper driver with index-sensor calibration
//
// req_bus carries one transaction per tick or command: operation (tick,
// start calibration, start run, status query), the index sensor level and
// the run length in eighths of a revolution. rsp_bus returns exactly one
// transaction per request: coil pattern, moving and calibrated flags,
// measured steps per revolution and a status code.
//
// a request is handled in the cycle it is accepted; its response is registered
// in the output register, or in the skid entry when rsp_bus stalls, and one
// request can be taken every cycle while the skid entry is empty. the per-request
// work is a table lookup, a counter step and one small multiply for the run length.
//
// when rsp_bus stalls, one more request is still taken into a skid entry,
// after which req_bus.ready drops; it comes back the cycle after the held
// response is taken and the skid entry moves into the output register.
// reset clears the motion state, the calibration and the coils (all off)
// and empties both response entries.
module stepper_half_step_calibrating_driver_unit #(
   parameter int COUNT_WIDTH = stpcal_pkg::CountWidth
) (
   input  logic       clock,
   input  logic       reset,
   stpcal_req_if.sink   req_bus,
   stpcal_rsp_if.source rsp_bus
);

   logic                   req_ready;
   logic                   req_accept;
   stpcal_pkg::result_type core_result;
   stpcal_pkg::result_type rsp_data;

   assign req_bus.ready = req_ready;
   assign req_accept    = req_bus.valid && req_ready;

   // state and per-request logic
   stpcal_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .operation    (req_bus.operation),
      .sensor_level (req_bus.sensor_level),
      .run_eighths  (req_bus.run_eighths),
      .result       (core_result)
   );

   // response register and skid entry
   stpcal_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_ready),
      .in_data   (core_result),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.coil_pattern     = rsp_data.coil_pattern;
   assign rsp_bus.moving           = rsp_data.moving;
   assign rsp_bus.is_calibrated    = rsp_data.is_calibrated;
   assign rsp_bus.revolution_steps = rsp_data.revolution_steps;
   assign rsp_bus.status_code      = rsp_data.status_code;

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stpcal_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned RANDOM_ITEMS = 1450;

   // coil patterns of the half-step sequence, bit3 drives coil one
   localparam logic [3:0] HALF_STEP_SEQ [8] = '{
      4'b1000, 4'b1100, 4'b0100, 4'b0110, 4'b0010, 4'b0011, 4'b0001, 4'b1001
   };

   // mirror of the motor state and the queue of responses it implies
   class drive_scoreboard;
      mode_type    mode;
      logic [2:0]  phase;
      int unsigned index_cycles;
      logic [15:0] step_count;
      logic [15:0] run_goal;
      logic [15:0] per_rev;
      logic [15:0] eighth_size;
      bit          calibrated;
      logic [3:0]  coils;
      result_type  due_reports[$];
      int unsigned failures;

      function new();
         mode = MODE_IDLE;
         phase = '0;
         index_cycles = 0;
         step_count = '0;
         run_goal = '0;
         per_rev = '0;
         eighth_size = '0;
         calibrated = 1'b0;
         coils = '0;
         failures = 0;
      endfunction

      // drive the next half step
      function void next_coils();
         coils = HALF_STEP_SEQ[phase];
         phase = phase + 3'd1;
      endfunction

      // step counter holds at its top value
      function void bump_count();
         if (step_count != '1) begin
            step_count = step_count + 16'd1;
         end
      endfunction

      // update the motor state for one accepted transaction
      function void take_request(op_type op, logic sensor, logic [3:0] eighths);
         result_type  rpt;
         status_type  status;
         logic [31:0] goal;
         status = STATUS_OK;
         case (op)
            OP_TICK: begin
               case (mode)
                  MODE_SEEK: begin
                     next_coils();
                     if (!sensor) mode = MODE_LOW;
                  end
                  MODE_LOW: begin
                     next_coils();
                     bump_count();
                     if (sensor) mode = MODE_HIGH;
                  end
                  MODE_HIGH: begin
                     next_coils();
                     bump_count();
                     if (!sensor) begin
                        index_cycles++;
                        if (index_cycles >= 3) begin
                           per_rev = step_count / 16'd3;
                           eighth_size = per_rev / 16'd8;
                           calibrated = 1'b1;
                           run_goal = '0;
                           index_cycles = 0;
                           mode = MODE_IDLE;
                        end else begin
                           mode = MODE_LOW;
                        end
                     end
                  end
                  MODE_RUN: begin
                     next_coils();
                     bump_count();
                     if (step_count >= run_goal) mode = MODE_IDLE;
                  end
                  default: ;
               endcase
            end
            OP_CAL: begin
               if (mode != MODE_IDLE) begin
                  status = STATUS_BUSY;
               end else begin
                  step_count = '0;
                  index_cycles = 0;
                  mode = sensor ? MODE_SEEK : MODE_LOW;
               end
            end
            OP_RUN: begin
               if (mode != MODE_IDLE) begin
                  status = STATUS_BUSY;
               end else if (!calibrated) begin
                  status = STATUS_NOCAL;
               end else if (eighths > 4'd8) begin
                  status = STATUS_BADLEN;
               end else begin
                  // zero eighths means one whole turn
                  if (eighths == 4'd0) begin
                     goal = 32'(eighth_size) * 32'd8;
                  end else begin
                     goal = 32'(eighth_size) * 32'(eighths);
                     if (goal > 32'(per_rev)) goal = 32'(per_rev);
                  end
                  run_goal = goal[15:0];
                  step_count = '0;
                  if (run_goal != '0) mode = MODE_RUN;
               end
            end
            default: ;
         endcase
         rpt.coil_pattern = coils;
         rpt.moving = (mode != MODE_IDLE);
         rpt.is_calibrated = calibrated;
         rpt.revolution_steps = per_rev;
         rpt.status_code = status;
         due_reports.push_back(rpt);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      // compare one response with the oldest prediction
      function void match_report(result_type got);
         result_type want;
         if (due_reports.size() == 0) begin
            failures++;
            $display("%0t: response with none expected, actual %p", $time, got);
         end else begin
            want = due_reports.pop_front();
            compare_field("coil_pattern", 16'(want.coil_pattern), 16'(got.coil_pattern));
            compare_field("moving", 16'(want.moving), 16'(got.moving));
            compare_field("is_calibrated", 16'(want.is_calibrated),
                          16'(got.is_calibrated));
            compare_field("revolution_steps", want.revolution_steps,
                          got.revolution_steps);
            compare_field("status_code", 16'(want.status_code), 16'(got.status_code));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int unsigned elapsed_cycles = 0;
   int unsigned counted_items = 0;
   int unsigned burst_left = 0;
   drive_scoreboard board = new();

   stpcal_req_if req_if ();
   stpcal_rsp_if rsp_if ();

   stepper_half_step_calibrating_driver_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #6ns clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      elapsed_cycles <= elapsed_cycles + 1;
      if (elapsed_cycles == CYCLE_LIMIT) begin
         $display("stepper_half_step_calibrating_driver_unit regression: fail");
         $finish;
      end
   end

   // response side: checks every transaction and stalls on its own pattern
   initial begin
      result_type  seen;
      int unsigned style;
      int unsigned hold;
      int unsigned period;
      int unsigned stall_len;
      int unsigned beat;
      rsp_if.ready <= 1'b0;
      beat = 0;
      forever begin
         style = $urandom_range(0, 2);
         hold = $urandom_range(50, 400);
         period = $urandom_range(3, 8);
         stall_len = $urandom_range(1, 2);
         repeat (hold) begin
            @(posedge clock);
            if (!reset && rsp_if.valid && rsp_if.ready) begin
               seen.coil_pattern = rsp_if.coil_pattern;
               seen.moving = rsp_if.moving;
               seen.is_calibrated = rsp_if.is_calibrated;
               seen.revolution_steps = rsp_if.revolution_steps;
               seen.status_code = status_type'(rsp_if.status_code);
               board.match_report(seen);
            end
            beat++;
            case (style)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
               default: rsp_if.ready <= ((beat % period) >= stall_len);
            endcase
         end
      end
   end

   // send one transaction, with bursts and gaps on the request side
   task automatic issue_request(input op_type op, input logic sensor,
                                input logic [3:0] eighths);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (!(op == OP_TICK && board.mode == MODE_IDLE)) counted_items++;
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.sensor_level <= sensor;
      req_if.run_eighths <= eighths;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.take_request(op, sensor, eighths);
   endtask

   // hold off requests until every response is back
   task automatic wait_for_reports();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (board.due_reports.size() != 0) @(posedge clock);
   endtask

   // motion tick, now and then preceded by a stray command
   task automatic tick_motor(input logic sensor);
      if ($urandom_range(0, 99) < 6) begin
         issue_request(op_type'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                       4'($urandom_range(0, 15)));
      end
      issue_request(OP_TICK, sensor, 4'($urandom_range(0, 15)));
   endtask

   // tick with the sensor level that moves any motion toward its end
   task automatic settle_motion();
      while (board.mode != MODE_IDLE) begin
         case (board.mode)
            MODE_SEEK, MODE_HIGH: tick_motor(1'b0);
            MODE_LOW: tick_motor(1'b1);
            default: tick_motor(1'($urandom_range(0, 1)));
         endcase
      end
   endtask

   task automatic calibration_pass();
      int unsigned longest;
      logic        start_level;
      settle_motion();
      longest = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      start_level = 1'($urandom_range(0, 1));
      issue_request(OP_CAL, start_level, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 6) == 0) begin
         // ragged sensor trace, left for the next pass to finish
         repeat ($urandom_range(0, 30)) tick_motor(1'($urandom_range(0, 1)));
      end else begin
         if (start_level) begin
            repeat ($urandom_range(0, 5)) tick_motor(1'b1);
            tick_motor(1'b0);
         end
         // three low-then-high index cycles
         repeat (3) begin
            repeat ($urandom_range(0, longest)) tick_motor(1'b0);
            tick_motor(1'b1);
            repeat ($urandom_range(0, longest)) tick_motor(1'b1);
            tick_motor(1'b0);
         end
      end
   endtask

   task automatic run_pass();
      logic [3:0] eighths;
      settle_motion();
      eighths = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
      issue_request(OP_RUN, 1'($urandom_range(0, 1)), eighths);
      while (board.mode != MODE_IDLE) tick_motor(1'($urandom_range(0, 1)));
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 5)) begin
         issue_request(op_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       4'($urandom_range(0, 15)));
      end
   endtask

   // status codes, busy commands, a tiny calibration and zero-length runs
   task automatic directed_checks();
      issue_request(OP_QUERY, 1'b1, 4'd0);
      issue_request(OP_TICK, 1'b1, 4'd15);
      issue_request(OP_RUN, 1'b0, 4'd4);
      issue_request(OP_RUN, 1'b1, 4'd9);
      issue_request(OP_CAL, 1'b1, 4'd0);
      issue_request(OP_CAL, 1'b0, 4'd0);
      issue_request(OP_RUN, 1'b0, 4'd15);
      issue_request(OP_QUERY, 1'b0, 4'd15);
      issue_request(OP_TICK, 1'b1, 4'd0);
      issue_request(OP_TICK, 1'b0, 4'd0);
      repeat (3) begin
         issue_request(OP_TICK, 1'b1, 4'd0);
         issue_request(OP_TICK, 1'b0, 4'd0);
      end
      // coils hold while idle
      issue_request(OP_TICK, 1'b0, 4'd0);
      issue_request(OP_RUN, 1'b0, 4'd15);
      issue_request(OP_RUN, 1'b0, 4'd0);
      issue_request(OP_RUN, 1'b1, 4'd8);
      // sensor already at index, seek skipped
      issue_request(OP_CAL, 1'b0, 4'd0);
      settle_motion();
   endtask

   // main sequence
   initial begin
      int unsigned random_goal;
      int unsigned pick;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.operation <= OP_TICK;
      req_if.sensor_level <= 1'b1;
      req_if.run_eighths <= 4'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed_checks();
      wait_for_reports();

      random_goal = counted_items + RANDOM_ITEMS;
      calibration_pass();
      while (counted_items < random_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            calibration_pass();
         end else if (pick < 80) begin
            run_pass();
         end else begin
            noise_burst();
         end
         if ($urandom_range(0, 19) == 0) wait_for_reports();
      end

      wait_for_reports();
      repeat (4) @(posedge clock);
      if (board.failures == 0) begin
         $display("stepper_half_step_calibrating_driver_unit regression: pass");
      end else begin
         $display("stepper_half_step_calibrating_driver_unit regression: fail");
      end
      $finish;
   end

endmodule
